/* src/hmrs_pkg.sv */
// Shared types and constants for the height-map relief shading block.
package hmrs_pkg;

    // Field and register widths
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int LW_W   = 12;
    localparam int GAIN_W = 16;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 1'b1;

    // Register reset values
    localparam logic [LW_W-1:0]   LW_RESET   = 12'd640;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1044;

    // Input word commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Store word layout: blue, green, red, then height
    localparam int STORE_W = NUM_CH * CH_W + CH_W;

    // Division of the shading product by 2048 * 255.
    // Low bits drop by shift, the rest is divided by 255 via reciprocal.
    localparam int              LOW_BITS    = 11;
    localparam int              BIAS_Q      = 2048;
    localparam int              BIAS_A      = BIAS_Q * 255;
    localparam int              A_W         = 20;
    localparam int              Q_W         = 12;
    localparam int              RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP    = 21'd1052689;
    localparam int              RECIP_SHIFT = 28;
    localparam int              PROD_Q_W    = A_W + RECIP_W;
    // Half of the divisor, split into the /255 remainder and the low bits
    localparam logic [CH_W-1:0]     HALF_REM_HI = 8'd127;
    localparam logic [LOW_BITS-1:0] HALF_REM_LO = 11'd1024;

    // Controller to datapath commands
    typedef struct packed {
        logic take;
        logic ld_gain;
        logic ld_mulm;
        logic ld_divq;
        logic ld_fix;
        logic ld_out;
        logic sel_raw;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic drain;
        logic result;
        logic out_free;
    } stat_t;

endpackage

/* src/hmrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hmrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read; a read of the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/hmrs_ctrl.sv */
// Sequencing state machine for the relief shading block.
module hmrs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  hmrs_pkg::stat_t   stat,
    output hmrs_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_GAIN = 6'b000010,
        ST_MULM = 6'b000100,
        ST_DIVQ = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   drain_reg;
    logic   drain_next;
    logic   take;

    assign take     = (state_reg == ST_IDLE) && in_valid;
    assign in_stall = (state_reg != ST_IDLE);

    // Choose the next state
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (stat.drain)
                    begin
                        drain_next = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (stat.result)
                    begin
                        drain_next = 1'b0;
                        state_next = ST_GAIN;
                    end
                end
            end
            ST_GAIN: state_next = ST_MULM;
            ST_MULM: state_next = ST_DIVQ;
            ST_DIVQ: state_next = ST_FIX;
            ST_FIX:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.take    = take;
        cmd.ld_gain = (state_reg == ST_GAIN);
        cmd.ld_mulm = (state_reg == ST_MULM);
        cmd.ld_divq = (state_reg == ST_DIVQ);
        cmd.ld_fix  = (state_reg == ST_FIX);
        cmd.ld_out  = (state_reg == ST_EMIT) && stat.out_free;
        cmd.sel_raw = drain_reg;
    end

endmodule

/* src/hmrs_datapath.sv */
// Row store, position counters, shading arithmetic and output register.
module hmrs_datapath #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  hmrs_pkg::cmd_t                         cmd,
    output hmrs_pkg::stat_t                        stat,
    input  logic                                   cfg_write,
    input  logic [hmrs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hmrs_pkg::GAIN_W-1:0]            cfg_data,
    input  logic                                   command,
    input  logic                                   start_of_frame,
    input  logic [hmrs_pkg::CH_W-1:0]              blue_in,
    input  logic [hmrs_pkg::CH_W-1:0]              green_in,
    input  logic [hmrs_pkg::CH_W-1:0]              red_in,
    input  logic [hmrs_pkg::CH_W-1:0]              height_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [hmrs_pkg::CH_W-1:0]              blue_out,
    output logic [hmrs_pkg::CH_W-1:0]              green_out,
    output logic [hmrs_pkg::CH_W-1:0]              red_out
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > hmrs_pkg::LW_W) ? CW : hmrs_pkg::LW_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
    localparam int CH_W   = hmrs_pkg::CH_W;
    localparam int NUM_CH = hmrs_pkg::NUM_CH;
    localparam int PG_W   = hmrs_pkg::GAIN_W + CH_W + 1;
    localparam int PM_W   = 32;
    localparam int A_W    = hmrs_pkg::A_W;
    localparam int Q_W    = hmrs_pkg::Q_W;
    localparam int LB     = hmrs_pkg::LOW_BITS;
    localparam int T_W    = 14;

    // Configuration registers
    logic [hmrs_pkg::LW_W-1:0]   line_width_reg;
    logic [hmrs_pkg::GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= hmrs_pkg::LW_RESET;
            gain_reg       <= hmrs_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hmrs_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_data[hmrs_pkg::LW_W-1:0];
                hmrs_pkg::REG_GAIN:       gain_reg       <= cfg_data;
                default:                  gain_reg       <= gain_reg;
            endcase
        end
    end

    // Clamp the line width to 1..MAX_WIDTH
    logic [WW-1:0] lw_ext;
    logic [WW-1:0] w_use;

    assign lw_ext = WW'(line_width_reg);
    assign w_use  = (lw_ext == '0) ? WW'(1) : ((lw_ext > MAX_W) ? MAX_W : lw_ext);

    // Position counters
    logic [AW-1:0] column_index_reg;
    logic [AW-1:0] column_index_next;
    logic          first_row_reg;
    logic          first_row_next;
    logic [AW-1:0] drain_index_reg;
    logic [AW-1:0] drain_index_next;

    logic [AW-1:0] col_base;
    logic          first_eff;
    logic [AW-1:0] col;
    logic [WW-1:0] col_inc;
    logic          col_wrap;
    logic [AW-1:0] didx;
    logic [WW-1:0] didx_inc;
    logic          is_drain;

    assign is_drain  = (command == hmrs_pkg::CMD_DRAIN);
    assign col_base  = start_of_frame ? '0 : column_index_reg;
    assign first_eff = start_of_frame ? 1'b1 : first_row_reg;
    assign col       = (WW'(col_base) >= w_use) ? '0 : col_base;
    assign col_inc   = WW'(col) + WW'(1);
    assign col_wrap  = (col_inc >= w_use);
    assign didx      = (WW'(drain_index_reg) >= w_use) ? '0 : drain_index_reg;
    assign didx_inc  = WW'(didx) + WW'(1);

    // Advance counters on an accepted word
    always_comb
    begin
        column_index_next = column_index_reg;
        first_row_next    = first_row_reg;
        drain_index_next  = drain_index_reg;
        if (cmd.take)
        begin
            if (is_drain)
            begin
                drain_index_next = (didx_inc >= w_use) ? '0 : didx_inc[AW-1:0];
            end
            else
            begin
                drain_index_next  = '0;
                column_index_next = col_wrap ? '0 : col_inc[AW-1:0];
                first_row_next    = col_wrap ? 1'b0 : first_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg <= '0;
            first_row_reg    <= 1'b1;
            drain_index_reg  <= '0;
        end
        else
        begin
            column_index_reg <= column_index_next;
            first_row_reg    <= first_row_next;
            drain_index_reg  <= drain_index_next;
        end
    end

    assign stat.drain  = is_drain;
    assign stat.result = !first_eff;

    // Row store: one word per column holding color and height
    logic                         st_wr_en;
    logic [hmrs_pkg::STORE_W-1:0] st_wr_data;
    logic [AW-1:0]                st_rd_addr;
    logic [hmrs_pkg::STORE_W-1:0] st_rd_data;

    assign st_wr_en   = cmd.take && !is_drain;
    assign st_wr_data = {height_value, red_in, green_in, blue_in};
    assign st_rd_addr = is_drain ? didx : col;

    hmrs_ram #(
        .WIDTH (hmrs_pkg::STORE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (col),
        .wr_data (st_wr_data),
        .rd_en   (cmd.take),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // Hold the new height for the increase
    logic [CH_W-1:0] height_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            height_reg <= height_value;
        end
    end

    // Gain times height increase
    logic signed [CH_W:0]   inc;
    logic signed [PG_W-1:0] prodg_reg;

    assign inc = $signed({1'b0, height_reg})
               - $signed({1'b0, st_rd_data[NUM_CH*CH_W +: CH_W]});

    always_ff @(posedge clk)
    begin
        if (cmd.ld_gain)
        begin
            prodg_reg <= $signed(gain_reg) * inc;
        end
    end

    // Per-channel lanes
    logic [CH_W-1:0] shade_reg [NUM_CH];

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        logic [CH_W-1:0]              c;
        logic [CH_W-2:0]              m;
        logic signed [PG_W+CH_W-1:0]  pm_full;
        logic signed [PM_W-1:0]       prodm_reg;
        logic signed [PM_W-LB-1:0]    pm_hi;
        logic signed [PM_W-1:0]       a_full;
        logic [A_W-1:0]               a;
        logic [hmrs_pkg::PROD_Q_W-1:0] qp;
        logic [A_W-1:0]               a_reg;
        logic [Q_W-1:0]               q_reg;
        logic [LB-1:0]                r0_reg;
        logic [A_W-1:0]               q255;
        logic [A_W-1:0]               rr;
        logic                         fix;
        logic [Q_W-1:0]               qf;
        logic [A_W-1:0]               rr_fix;
        logic [CH_W-1:0]              rf;
        logic                         tie;
        logic                         up;
        logic                         rnd;
        logic signed [T_W-1:0]        t;

        assign c = st_rd_data[ch*CH_W +: CH_W];
        // min(c, 255 - c) fits seven bits
        assign m = c[CH_W-1] ? ~c[CH_W-2:0] : c[CH_W-2:0];

        // Multiply by the distance from the nearest rail
        assign pm_full = prodg_reg * $signed({1'b0, m});

        always_ff @(posedge clk)
        begin
            if (cmd.ld_mulm)
            begin
                prodm_reg <= $signed(pm_full[PM_W-1:0]);
            end
        end

        // Drop the low bits, bias positive, estimate the quotient by 255
        assign pm_hi  = prodm_reg[PM_W-1:LB];
        assign a_full = PM_W'(pm_hi) + PM_W'(hmrs_pkg::BIAS_A);
        assign a      = a_full[A_W-1:0];
        assign qp     = hmrs_pkg::PROD_Q_W'(a) * hmrs_pkg::PROD_Q_W'(hmrs_pkg::RECIP);

        always_ff @(posedge clk)
        begin
            if (cmd.ld_divq)
            begin
                a_reg  <= a;
                q_reg  <= qp[hmrs_pkg::RECIP_SHIFT +: Q_W];
                r0_reg <= prodm_reg[LB-1:0];
            end
        end

        // Correct the quotient, round half to even, saturate
        assign q255   = (A_W'(q_reg) << CH_W) - A_W'(q_reg);
        assign rr     = a_reg - q255;
        assign fix    = (rr >= A_W'(255));
        assign qf     = q_reg + Q_W'(fix);
        assign rr_fix = fix ? (rr - A_W'(255)) : rr;
        assign rf     = rr_fix[CH_W-1:0];
        assign tie    = (rf == hmrs_pkg::HALF_REM_HI) && (r0_reg == hmrs_pkg::HALF_REM_LO);
        assign up     = (rf > hmrs_pkg::HALF_REM_HI)
                     || ((rf == hmrs_pkg::HALF_REM_HI) && (r0_reg > hmrs_pkg::HALF_REM_LO));
        assign rnd    = up || (tie && (c[0] ^ qf[0]));
        assign t      = $signed({{(T_W-CH_W){1'b0}}, c})
                     + $signed({{(T_W-Q_W){1'b0}}, qf})
                     - $signed(T_W'(hmrs_pkg::BIAS_Q))
                     + $signed({{(T_W-1){1'b0}}, rnd});

        always_ff @(posedge clk)
        begin
            if (cmd.ld_fix)
            begin
                if (t < 0)
                begin
                    shade_reg[ch] <= '0;
                end
                else if (t > $signed(T_W'(255)))
                begin
                    shade_reg[ch] <= '1;
                end
                else
                begin
                    shade_reg[ch] <= t[CH_W-1:0];
                end
            end
        end
    end

    // Output register
    logic            out_valid_reg;
    logic [CH_W-1:0] blue_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] red_reg;

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the drained color unchanged or the shaded color
    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            if (cmd.sel_raw)
            begin
                blue_reg  <= st_rd_data[0*CH_W +: CH_W];
                green_reg <= st_rd_data[1*CH_W +: CH_W];
                red_reg   <= st_rd_data[2*CH_W +: CH_W];
            end
            else
            begin
                blue_reg  <= shade_reg[0];
                green_reg <= shade_reg[1];
                red_reg   <= shade_reg[2];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign blue_out  = blue_reg;
    assign green_out = green_reg;
    assign red_out   = red_reg;

endmodule

/* src/height_map_relief_shading.sv */
// Top level of the height-map relief shading block.
// Pixels arrive in raster order with a color and a height; each pixel's color is
// shaded by how much higher the pixel directly below it is, so a pixel's shaded
// word leaves when the pixel below it is accepted, and last-row pixels leave
// unchanged through drain commands. The block works on one word at a time: a
// first-row pixel is only stored, a drain goes straight to the output load, and a
// pixel that yields a shaded word steps through row store read, gain multiply,
// rail-distance multiply, reciprocal divide by 255, round and saturate, and output
// load, which waits on out_stall. The input side is free again once the word is in
// the output register. The row store holds MAX_WIDTH words and needs no clearing.
module height_map_relief_shading #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [hmrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hmrs_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic                                start_of_frame,
    input  logic [hmrs_pkg::CH_W-1:0]           blue_in,
    input  logic [hmrs_pkg::CH_W-1:0]           green_in,
    input  logic [hmrs_pkg::CH_W-1:0]           red_in,
    input  logic [hmrs_pkg::CH_W-1:0]           height_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hmrs_pkg::CH_W-1:0]           blue_out,
    output logic [hmrs_pkg::CH_W-1:0]           green_out,
    output logic [hmrs_pkg::CH_W-1:0]           red_out
);

    hmrs_pkg::cmd_t  cmd;
    hmrs_pkg::stat_t stat;

    hmrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hmrs_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .start_of_frame (start_of_frame),
        .blue_in        (blue_in),
        .green_in       (green_in),
        .red_in         (red_in),
        .height_value   (height_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .blue_out       (blue_out),
        .green_out      (green_out),
        .red_out        (red_out)
    );

endmodule

/* dv/relief_shade_monitor.sv */
`timescale 1ns / 100ps
// Monitor for the relief shading block: predicts each output word, shaded or drained, and compares it.
module relief_shade_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [hmrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hmrs_pkg::GAIN_W-1:0]    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           command,
    input  logic                           start_of_frame,
    input  logic [hmrs_pkg::CH_W-1:0]      blue_in,
    input  logic [hmrs_pkg::CH_W-1:0]      green_in,
    input  logic [hmrs_pkg::CH_W-1:0]      red_in,
    input  logic [hmrs_pkg::CH_W-1:0]      height_value,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [hmrs_pkg::CH_W-1:0]      blue_out,
    input  logic [hmrs_pkg::CH_W-1:0]      green_out,
    input  logic [hmrs_pkg::CH_W-1:0]      red_out,
    output int                             mismatches,
    output int                             in_flight
);

    localparam int     ROW_MAX    = 2048;
    localparam int     REPORT_MAX = 10;
    // gain has 12 fraction bits and the rail distance is scaled by 255
    localparam longint FULL_SCALE = 4096 * 255;
    // keeps the sum positive so integer division floors
    localparam longint LIFT       = 4096;

    typedef struct packed {
        logic [hmrs_pkg::CH_W-1:0] blue;
        logic [hmrs_pkg::CH_W-1:0] green;
        logic [hmrs_pkg::CH_W-1:0] red;
    } color_t;

    color_t                             color_row [ROW_MAX];
    logic [hmrs_pkg::CH_W-1:0]          height_row [ROW_MAX];
    int                                 col_pos;
    int                                 drain_pos;
    bit                                 on_top_row;
    logic [hmrs_pkg::LW_W-1:0]          row_len;
    logic signed [hmrs_pkg::GAIN_W-1:0] light_gain;
    color_t                             shaded_queue [$];

    // Clamp the programmed row length to the range the store supports
    function automatic int row_span(input logic [hmrs_pkg::LW_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > ROW_MAX)
            return ROW_MAX;
        return int'(len);
    endfunction

    // Shift one channel by gain * rise * min(c, 255 - c) / 127.5, round half even, saturate
    function automatic logic [hmrs_pkg::CH_W-1:0] shade_level(
        input logic [hmrs_pkg::CH_W-1:0] c, input int rise,
        input logic signed [hmrs_pkg::GAIN_W-1:0] g);
        longint level;
        longint rail;
        longint total;
        longint quo;
        longint rem;
        longint res;
        level = longint'(c);
        rail  = (level < 255 - level) ? level : 255 - level;
        total = level * FULL_SCALE + longint'(g) * rise * rail * 2 + LIFT * FULL_SCALE;
        quo   = total / FULL_SCALE;
        rem   = total % FULL_SCALE;
        if (2 * rem > FULL_SCALE || (2 * rem == FULL_SCALE && quo % 2 == 1))
            quo++;
        res = quo - LIFT;
        if (res < 0)
            res = 0;
        else if (res > 255)
            res = 255;
        return res[hmrs_pkg::CH_W-1:0];
    endfunction

    // Count a bad output word and report the first few
    task automatic note_fault(input string what, input color_t want, input color_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d", $realtime,
                     what, want.blue, want.green, want.red, got.blue, got.green, got.red);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        color_t got;
        color_t want;
        color_t stored;
        int     span;
        int     col;
        int     rise;
        if (!rst_n)
        begin
            col_pos    = 0;
            drain_pos  = 0;
            on_top_row = 1'b1;
            row_len    = hmrs_pkg::LW_RESET;
            light_gain = hmrs_pkg::GAIN_RESET;
            shaded_queue.delete();
            mismatches = 0;
            in_flight  = 0;
        end
        else
        begin
            // Compare the returned word with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.blue  = blue_out;
                got.green = green_out;
                got.red   = red_out;
                if (shaded_queue.size() == 0)
                begin
                    note_fault("unexpected word", '0, got);
                end
                else
                begin
                    want = shaded_queue.pop_front();
                    if (want.blue !== got.blue || want.green !== got.green
                        || want.red !== got.red)
                        note_fault("word mismatch", want, got);
                end
            end

            // Advance the row model on an accepted input word
            if (in_valid && !in_stall)
            begin
                span = row_span(row_len);
                if (command == hmrs_pkg::CMD_DRAIN)
                begin
                    col = (drain_pos >= span) ? 0 : drain_pos;
                    shaded_queue.push_back(color_row[col]);
                    col++;
                    drain_pos = (col >= span) ? 0 : col;
                end
                else
                begin
                    if (start_of_frame)
                    begin
                        col_pos    = 0;
                        on_top_row = 1'b1;
                    end
                    col       = (col_pos >= span) ? 0 : col_pos;
                    drain_pos = 0;
                    // Shade the stored pixel above by the height rise
                    if (!on_top_row)
                    begin
                        rise       = int'(height_value) - int'(height_row[col]);
                        stored     = color_row[col];
                        want.blue  = shade_level(stored.blue, rise, light_gain);
                        want.green = shade_level(stored.green, rise, light_gain);
                        want.red   = shade_level(stored.red, rise, light_gain);
                        shaded_queue.push_back(want);
                    end
                    stored.blue      = blue_in;
                    stored.green     = green_in;
                    stored.red       = red_in;
                    color_row[col]   = stored;
                    height_row[col]  = height_value;
                    col++;
                    if (col >= span)
                    begin
                        col        = 0;
                        on_top_row = 1'b0;
                    end
                    col_pos = col;
                end
            end

            // Track register writes
            if (cfg_write)
            begin
                if (cfg_index == hmrs_pkg::REG_LINE_WIDTH)
                    row_len = cfg_data[hmrs_pkg::LW_W-1:0];
                else if (cfg_index == hmrs_pkg::REG_GAIN)
                    light_gain = cfg_data;
            end

            in_flight = shaded_queue.size();
        end
    end

endmodule

/* dv/height_map_relief_shading_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the relief shading block: clock, reset, stimulus and verdict.
module height_map_relief_shading_tb;

    localparam int ROW_MAX     = 2048;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [hmrs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hmrs_pkg::GAIN_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           command;
    logic                           start_of_frame;
    logic [hmrs_pkg::CH_W-1:0]      blue_in;
    logic [hmrs_pkg::CH_W-1:0]      green_in;
    logic [hmrs_pkg::CH_W-1:0]      red_in;
    logic [hmrs_pkg::CH_W-1:0]      height_value;
    logic                           out_valid;
    logic                           out_stall;
    logic [hmrs_pkg::CH_W-1:0]      blue_out;
    logic [hmrs_pkg::CH_W-1:0]      green_out;
    logic [hmrs_pkg::CH_W-1:0]      red_out;
    int                             mismatches;
    int                             in_flight;

    bit                             quiet_tail = 1'b0;
    bit                             hold_req = 1'b0;
    int                             idle_cycles = 0;

    // Row position as the block sees it, kept so no unwritten store entry is read
    int                             lane_width;
    int                             next_col;
    bit                             top_row;
    int                             drain_col;
    bit                             filled [ROW_MAX];

    height_map_relief_shading DUT (.*);

    relief_shade_monitor shade_mon (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT - 1)
        begin
            $display("height_map_relief_shading_tb: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stall bursts, one long hold-off on request
    initial
    begin : out_side
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < 8)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Pick a level, biased toward the rails
    function automatic logic [hmrs_pkg::CH_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return hmrs_pkg::CH_W'($urandom_range(0, 255));
    endfunction

    // Write both registers; call at a falling edge with the block idle
    task automatic write_config(input int span_reg, input int gain_reg);
        cfg_write <= 1'b1;
        cfg_index <= hmrs_pkg::REG_LINE_WIDTH;
        cfg_data  <= span_reg[hmrs_pkg::GAIN_W-1:0];
        @(negedge clk);
        cfg_index <= hmrs_pkg::REG_GAIN;
        cfg_data  <= gain_reg[hmrs_pkg::GAIN_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        if (span_reg[hmrs_pkg::LW_W-1:0] == 0)
            lane_width = 1;
        else if (span_reg[hmrs_pkg::LW_W-1:0] > ROW_MAX)
            lane_width = ROW_MAX;
        else
            lane_width = int'(span_reg[hmrs_pkg::LW_W-1:0]);
    endtask

    // Offer one word and hold it until accepted; starts and ends at a falling edge
    task automatic put_word(input bit drain, input bit sof,
                            input logic [hmrs_pkg::CH_W-1:0] b,
                            input logic [hmrs_pkg::CH_W-1:0] g,
                            input logic [hmrs_pkg::CH_W-1:0] r,
                            input logic [hmrs_pkg::CH_W-1:0] h);
        bit use_drain;
        bit use_sof;
        int idx;
        int col;
        use_drain = drain;
        use_sof   = sof;
        idx       = (drain_col >= lane_width) ? 0 : drain_col;
        // A drain from an unwritten entry becomes a pixel
        if (use_drain && !filled[idx])
            use_drain = 1'b0;
        // A pixel below an unwritten entry starts a new frame instead
        if (!use_drain && !use_sof && !top_row)
        begin
            col = (next_col >= lane_width) ? 0 : next_col;
            if (!filled[col])
                use_sof = 1'b1;
        end

        if (!quiet_tail && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        command        <= use_drain ? hmrs_pkg::CMD_DRAIN : hmrs_pkg::CMD_PIXEL;
        start_of_frame <= use_sof;
        blue_in        <= b;
        green_in       <= g;
        red_in         <= r;
        height_value   <= h;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);

        // Advance the row position
        if (use_drain)
        begin
            idx++;
            drain_col = (idx >= lane_width) ? 0 : idx;
        end
        else
        begin
            if (use_sof)
            begin
                next_col = 0;
                top_row  = 1'b1;
            end
            col          = (next_col >= lane_width) ? 0 : next_col;
            drain_col    = 0;
            filled[col]  = 1'b1;
            col++;
            if (col >= lane_width)
            begin
                col     = 0;
                top_row = 1'b0;
            end
            next_col = col;
        end
    endtask

    task automatic put_random(input bit drain, input bit sof);
        put_word(drain, sof, pick_level(), pick_level(), pick_level(), pick_level());
    endtask

    // Drop valid, wait for every predicted word, then let the block go quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // One setting: frames of random rows, each followed by a drain of its last row or of a random number of words
    task automatic run_phase(input int span_reg, input int gain_reg, input int budget);
        int sent;
        int k;
        int rows;
        int tail;
        write_config(span_reg, gain_reg);
        sent = 0;
        while (sent < budget)
        begin
            // drain ahead of the frame, possibly past a narrowed row
            if ($urandom_range(0, 99) < 15)
            begin
                put_random(1'b1, 1'($urandom_range(0, 1)));
                sent++;
            end
            rows = $urandom_range(1, 4);
            for (k = 0; k < rows * lane_width && sent < budget; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                begin
                    put_random(1'b1, 1'b0);
                    sent++;
                end
                put_random(1'b0, (k == 0) ? ($urandom_range(0, 99) < 75)
                                          : ($urandom_range(0, 99) < 2));
                sent++;
            end
            tail = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lane_width + 2) : lane_width;
            for (k = 0; k < tail && sent < budget; k++)
            begin
                put_random(1'b1, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        settle_block();
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = hmrs_pkg::REG_LINE_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = hmrs_pkg::CMD_PIXEL;
        start_of_frame = 1'b0;
        blue_in        = '0;
        green_in       = '0;
        red_in         = '0;
        height_value   = '0;
        lane_width     = int'(hmrs_pkg::LW_RESET);
        next_col       = 0;
        top_row        = 1'b1;
        drain_col      = 0;
        foreach (filled[i])
            filled[i] = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Rails, full-scale rises and falls, saturation, drain wrap, mid-row restart
        write_config(3, 32767);
        put_word(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
        put_word(1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
        put_word(1'b0, 1'b0, 8'd127, 8'd128, 8'd1, 8'd128);
        put_word(1'b0, 1'b0, 8'd10, 8'd245, 8'd128, 8'd255);
        put_word(1'b0, 1'b0, 8'd200, 8'd50, 8'd90, 8'd0);
        put_word(1'b0, 1'b0, 8'd60, 8'd130, 8'd250, 8'd255);
        put_word(1'b1, 1'b1, 8'd255, 8'd0, 8'd255, 8'd0);
        put_word(1'b1, 1'b0, 8'd0, 8'd255, 8'd0, 8'd255);
        put_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        put_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        put_word(1'b0, 1'b1, 8'd33, 8'd66, 8'd99, 8'd12);
        put_word(1'b0, 1'b0, 8'd44, 8'd88, 8'd132, 8'd200);
        put_word(1'b0, 1'b1, 8'd5, 8'd250, 8'd128, 8'd77);
        settle_block();

        // Exact half results: round to even in both directions
        write_config(2, 1024);
        put_word(1'b0, 1'b1, 8'd1, 8'd254, 8'd1, 8'd0);
        put_word(1'b0, 1'b0, 8'd254, 8'd1, 8'd254, 8'd255);
        put_word(1'b0, 1'b0, 8'd9, 8'd9, 8'd9, 8'd255);
        put_word(1'b0, 1'b0, 8'd9, 8'd9, 8'd9, 8'd0);
        put_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        put_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        settle_block();

        // Random settings, the extremes among them
        run_phase(5, $urandom_range(0, 65535), 200);
        run_phase(1, 32767, 80);
        run_phase(0, -32768, 80);
        // hold the output off while words keep coming in
        hold_req = 1'b1;
        run_phase(13, $urandom_range(0, 65535), 200);
        run_phase(4095, $urandom_range(0, 65535), 60);
        run_phase(3, 0, 100);
        run_phase(7, $urandom_range(0, 65535), 250);
        quiet_tail = 1'b1;
        run_phase(2, $urandom_range(0, 65535), 150);

        if (mismatches == 0)
            $display("height_map_relief_shading_tb: done, clean");
        else
            $display("height_map_relief_shading_tb: done, errors");
        $finish;
    end

endmodule
